@@ sv/lbp_pkg.sv @@
// lbp_pkg: shared constants, types and helpers of the 3x3 lbp code stream
// no dependencies; compile first
`timescale 1ns / 1ps

package lbp_pkg;

    // fixed field widths
    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // default frame limits and register reset values
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // result queue depth, in records of up to two results
    localparam int QDEPTH  = 4;
    localparam int Q_IDX_W = 2;
    localparam int Q_CNT_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // what one pixel causes
    typedef struct packed {
        logic interior;   // code for the pixel up and to the left
        logic border;     // this pixel passes through
    } pos_flags_t;

    // last index of a dimension: zero acts as one, above the maximum acts as the maximum
    function automatic int unsigned clamp_last(logic [CFG_W-1:0] v, int unsigned maxv);
        int unsigned vi;
        vi = int'(v);
        if (vi == 0)
            return 0;
        else if (vi > maxv)
            return maxv - 1;
        else
            return vi - 1;
    endfunction

endpackage

@@ sv/lbp_if.sv @@
// lbp_if: valid/ready channels for pixels in and tagged results out
// depends on lbp_pkg
`timescale 1ns / 1ps

interface lbp_pixel_if;
    import lbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_result_if;
    import lbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] code;
    logic             last_of_run;

    modport source (output valid, output out_row, output out_col, output code,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input code,
                    input last_of_run, output ready);
endinterface

@@ sv/lbp_scan.sv @@
// lbp_scan: frame size registers, raster counters and the memory-read stage
// depends on lbp_pkg
`timescale 1ns / 1ps

module lbp_scan #(
    parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lbp_pkg::CFG_W-1:0]      wr_data,
    // accepted pixel
    input  logic                           accept,
    input  logic [lbp_pkg::PIX_W-1:0]      pixel,
    // line store request for this pixel
    output logic [COL_W-1:0]               mem_addr,
    output logic                           mem_bank,
    // stage after the memory read
    output logic                           s1_valid,
    output logic [ROW_W-1:0]               s1_row,
    output logic [COL_W-1:0]               s1_col,
    output logic [lbp_pkg::PIX_W-1:0]      s1_px,
    output lbp_pkg::pos_flags_t            s1_flags
);
    import lbp_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST_RST =
        COL_W'(clamp_last(CFG_W'(RESET_WIDTH), MAX_WIDTH));
    localparam logic [ROW_W-1:0] ROW_LAST_RST =
        ROW_W'(clamp_last(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
    localparam logic [COL_W-1:0] COL_TWO = COL_W'(2);
    localparam logic [ROW_W-1:0] ROW_TWO = ROW_W'(2);

    logic [COL_W-1:0] col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_px_reg;
    pos_flags_t       s1_flags_reg;
    pos_flags_t       flags;

    // position class of the incoming pixel
    always_comb
    begin
        flags.interior = (row_reg >= ROW_TWO) && (col_reg >= COL_TWO);
        flags.border   = (row_reg == '0) || (col_reg == '0) ||
                         (row_reg == row_last_reg) || (col_reg == col_last_reg);
    end

    // size registers and raster counters; a size write restarts the frame
    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_IMAGE_WIDTH:
                begin
                    col_last_next = COL_W'(clamp_last(wr_data, MAX_WIDTH));
                    col_next      = '0;
                    row_next      = '0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    row_last_next = ROW_W'(clamp_last(wr_data, MAX_HEIGHT));
                    col_next      = '0;
                    row_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_reg == col_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_LAST_RST;
            row_last_reg <= ROW_LAST_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // payload of the stage that meets the memory read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_px_reg    <= pixel;
            s1_flags_reg <= flags;
        end
    end

    assign mem_addr = col_reg;
    assign mem_bank = row_reg[0];
    assign s1_valid = s1_valid_reg;
    assign s1_row   = s1_row_reg;
    assign s1_col   = s1_col_reg;
    assign s1_px    = s1_px_reg;
    assign s1_flags = s1_flags_reg;

endmodule

@@ sv/lbp_line_store.sv @@
// lbp_line_store: two row banks, read-before-write, registered read
// depends on lbp_pkg
`timescale 1ns / 1ps

module lbp_line_store #(
    parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [COL_W-1:0]          addr,
    input  logic                      bank,
    input  logic [lbp_pkg::PIX_W-1:0] wr_data,
    output logic [lbp_pkg::PIX_W-1:0] up2,
    output logic [lbp_pkg::PIX_W-1:0] up1
);
    import lbp_pkg::*;

    logic [PIX_W-1:0] bank0_mem [MAX_WIDTH];
    logic [PIX_W-1:0] bank1_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd0_reg;
    logic [PIX_W-1:0] rd1_reg;
    logic             bank_reg;

    // bank of even rows: old value read out, new pixel written
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd0_reg <= bank0_mem[addr];
            if (!bank)
                bank0_mem[addr] <= wr_data;
        end
    end

    // bank of odd rows
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd1_reg <= bank1_mem[addr];
            if (bank)
                bank1_mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            bank_reg <= bank;
    end

    // own bank holds two rows up, the other bank one row up
    assign up2 = bank_reg ? rd1_reg : rd0_reg;
    assign up1 = bank_reg ? rd0_reg : rd1_reg;

endmodule

@@ sv/lbp_window.sv @@
// lbp_window: 3x3 neighborhood registers and the eight-way compare
// depends on lbp_pkg
`timescale 1ns / 1ps

module lbp_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift,
    input  logic [lbp_pkg::PIX_W-1:0] up2,
    input  logic [lbp_pkg::PIX_W-1:0] up1,
    input  logic [lbp_pkg::PIX_W-1:0] px,
    output logic [lbp_pkg::PIX_W-1:0] code
);
    import lbp_pkg::*;

    // [row][0] left column, [row][1] middle column; the new right column comes in live
    logic [PIX_W-1:0] win_reg [3][2];
    logic [PIX_W-1:0] new_col [3];
    logic [PIX_W-1:0] ctr;

    assign new_col[0] = up2;
    assign new_col[1] = up1;
    assign new_col[2] = px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= '0;
                win_reg[i][1] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= new_col[i];
            end
        end
    end

    // bits clockwise from top-left at bit 7 to left at bit 0
    always_comb
    begin
        ctr     = win_reg[1][1];
        code[7] = win_reg[0][0] >= ctr;
        code[6] = win_reg[0][1] >= ctr;
        code[5] = up2           >= ctr;
        code[4] = up1           >= ctr;
        code[3] = px            >= ctr;
        code[2] = win_reg[2][1] >= ctr;
        code[1] = win_reg[2][0] >= ctr;
        code[0] = win_reg[1][0] >= ctr;
    end

endmodule

@@ sv/lbp_out_queue.sv @@
// lbp_out_queue: record queue that unpacks one or two results per pixel
// depends on lbp_pkg and lbp_if
`timescale 1ns / 1ps

module lbp_out_queue #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [ROW_W-1:0]             push_row,
    input  logic [COL_W-1:0]             push_col,
    input  logic [lbp_pkg::PIX_W-1:0]    push_code,
    input  logic [lbp_pkg::PIX_W-1:0]    push_px,
    input  lbp_pkg::pos_flags_t          push_flags,
    output logic                         room,
    output logic [lbp_pkg::Q_CNT_W-1:0]  count,
    lbp_result_if.source                 res
);
    import lbp_pkg::*;

    logic [ROW_W-1:0] row_mem   [QDEPTH];
    logic [COL_W-1:0] col_mem   [QDEPTH];
    logic [PIX_W-1:0] code_mem  [QDEPTH];
    logic [PIX_W-1:0] px_mem    [QDEPTH];
    pos_flags_t       flags_mem [QDEPTH];

    logic [Q_IDX_W-1:0] head_reg, head_next;
    logic [Q_IDX_W-1:0] tail_reg, tail_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               phase_reg, phase_next;

    pos_flags_t         head_flags;
    logic               emit_int;
    logic               xfer;
    logic               pop;

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            row_mem[tail_reg]   <= push_row;
            col_mem[tail_reg]   <= push_col;
            code_mem[tail_reg]  <= push_code;
            px_mem[tail_reg]    <= push_px;
            flags_mem[tail_reg] <= push_flags;
        end
    end

    // interior result first, then border result of the same pixel
    always_comb
    begin
        head_flags      = flags_mem[head_reg];
        emit_int        = head_flags.interior && !phase_reg;
        res.valid       = count_reg != '0;
        if (emit_int)
        begin
            res.out_row     = POS_W'(ROW_W'(row_mem[head_reg] - 1'b1));
            res.out_col     = POS_W'(COL_W'(col_mem[head_reg] - 1'b1));
            res.code        = code_mem[head_reg];
            res.last_of_run = !head_flags.border;
        end
        else
        begin
            res.out_row     = POS_W'(row_mem[head_reg]);
            res.out_col     = POS_W'(col_mem[head_reg]);
            res.code        = px_mem[head_reg];
            res.last_of_run = 1'b1;
        end
    end

    // queue pointers and sub-result phase
    always_comb
    begin
        xfer       = res.valid && res.ready;
        pop        = xfer && !(emit_int && head_flags.border);
        phase_next = phase_reg;
        if (xfer)
            phase_next = !pop;
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    // space for the record in flight plus one more
    assign room  = count_reg <= Q_CNT_W'(QDEPTH - 2);
    assign count = count_reg;

endmodule

@@ sv/lbp_3x3_code_stream.sv @@
// lbp_3x3_code_stream: top level of the streaming 3x3 local binary pattern
// depends on lbp_pkg, lbp_if, lbp_scan, lbp_line_store, lbp_window, lbp_out_queue
`timescale 1ns / 1ps

//  channel   direction  transfer moves                          handshake
//  pix       in         pixel                                   valid/ready
//  res       out        out_row, out_col, code, last_of_run     valid/ready
//  wr_*      in         register write (index, data)            wr_en only
//
// one pixel per clock sustained while pix.ready is high; a pixel that yields two
// results sends them as two output transfers. a result passes the line store
// read stage, then the result queue.
// the line store is not cleared after reset; rst_n clears counters, queue and
// window at once and the sizes go to 640 x 480.
// a stalled output fills a four-record queue; pix.ready drops at three records.

module lbp_3x3_code_stream #(
    parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lbp_pkg::CFG_W-1:0]     wr_data,
    lbp_pixel_if.sink                     pix,
    lbp_result_if.source                  res
);
    import lbp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic               accept;
    logic [COL_W-1:0]   mem_addr;
    logic               mem_bank;
    logic               s1_valid;
    logic [ROW_W-1:0]   s1_row;
    logic [COL_W-1:0]   s1_col;
    logic [PIX_W-1:0]   s1_px;
    pos_flags_t         s1_flags;
    logic [PIX_W-1:0]   up2;
    logic [PIX_W-1:0]   up1;
    logic [PIX_W-1:0]   code;
    logic               q_push;
    logic               q_room;
    logic [Q_CNT_W-1:0] q_count;

    // input transfer
    assign pix.ready = q_room;
    assign accept    = pix.valid && pix.ready;

    lbp_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .pixel    (pix.pixel),
        .mem_addr (mem_addr),
        .mem_bank (mem_bank),
        .s1_valid (s1_valid),
        .s1_row   (s1_row),
        .s1_col   (s1_col),
        .s1_px    (s1_px),
        .s1_flags (s1_flags)
    );

    lbp_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_store (
        .clk     (clk),
        .en      (accept),
        .addr    (mem_addr),
        .bank    (mem_bank),
        .wr_data (pix.pixel),
        .up2     (up2),
        .up1     (up1)
    );

    lbp_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_valid),
        .up2   (up2),
        .up1   (up1),
        .px    (s1_px),
        .code  (code)
    );

    // only pixels that cause a result take a queue record
    assign q_push = s1_valid && (s1_flags.interior || s1_flags.border);

    lbp_out_queue #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_row   (s1_row),
        .push_col   (s1_col),
        .push_code  (code),
        .push_px    (s1_px),
        .push_flags (s1_flags),
        .room       (q_room),
        .count      (q_count),
        .res        (res)
    );

    // the read stage is valid only in the cycle after an input transfer
    a_s1_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> $past(accept))
        else $error("read stage valid without a prior input transfer");

    // the queue never takes a record when full
    a_queue_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < Q_CNT_W'(QDEPTH)))
        else $error("result queue overflow");

    // a result that is not last is followed by the rest of its run
    a_run_completes : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && !res.last_of_run) |=> (res.valid && res.last_of_run))
        else $error("run of results cut short");

endmodule

@@ verif/lbp_code_checker.sv @@
// lbp_code_checker: watches the pixel, result and register write ports of the
// 3x3 lbp code stream, predicts every tagged result and compares in order
// depends on lbp_pkg and lbp_if
`timescale 1ns / 1ps

module lbp_code_checker
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    lbp_pixel_if                 pix,
    lbp_result_if                res,
    output int unsigned          error_count,
    output int unsigned          pending_count
);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] code;
        logic             last_of_run;
    } lbp_result_t;

    // predicted copy of the block state
    logic [PIX_W-1:0] row_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] nbhd [3][3];
    int unsigned      next_row;
    int unsigned      next_col;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    lbp_result_t      expected_q [$];
    int unsigned      fail_total;

    // usable size of a dimension: zero acts as one, too large acts as the limit
    function automatic int unsigned frame_dim(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    // one bit per neighbour >= centre, clockwise from top-left at bit 7
    function automatic logic [PIX_W-1:0] pattern_code();
        logic [PIX_W-1:0] ctr;
        ctr = nbhd[1][1];
        return {nbhd[0][0] >= ctr, nbhd[0][1] >= ctr, nbhd[0][2] >= ctr,
                nbhd[1][2] >= ctr, nbhd[2][2] >= ctr, nbhd[2][1] >= ctr,
                nbhd[2][0] >= ctr, nbhd[1][0] >= ctr};
    endfunction

    // one accepted pixel: update line rows and window, queue what it causes
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        int unsigned      cur_slot;
        int unsigned      old_slot;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        lbp_result_t      found [2];
        int               n;

        w = frame_dim(width_reg, MAX_WIDTH);
        h = frame_dim(height_reg, MAX_HEIGHT);
        r = next_row;
        c = next_col;
        cur_slot = (r % 2) * MAX_WIDTH + c;
        old_slot = ((r + 1) % 2) * MAX_WIDTH + c;
        above2 = '0;
        above1 = '0;
        if (r >= 2)
            above2 = row_mem[cur_slot];
        if (r >= 1)
            above1 = row_mem[old_slot];
        row_mem[cur_slot] = px;

        // slide the window left and bring in the new column
        for (int i = 0; i < 3; i++)
        begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = above2;
        nbhd[1][2] = above1;
        nbhd[2][2] = px;

        // interior code for the pixel up-left comes before this border pixel
        n = 0;
        if (r >= 2 && c >= 2)
        begin
            found[n].row         = POS_W'(r - 1);
            found[n].col         = POS_W'(c - 1);
            found[n].code        = pattern_code();
            found[n].last_of_run = 1'b0;
            n++;
        end
        if (r == 0 || c == 0 || r + 1 == h || c + 1 == w)
        begin
            found[n].row         = POS_W'(r);
            found[n].col         = POS_W'(c);
            found[n].code        = px;
            found[n].last_of_run = 1'b0;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            found[i].last_of_run = (i == n - 1);
            expected_q = {expected_q, found[i]};
        end

        // raster position of the next pixel
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    // one accepted result against the oldest expectation
    task automatic check_result();
        lbp_result_t got;
        lbp_result_t want;

        got.row         = res.out_row;
        got.col         = res.out_col;
        got.code        = res.code;
        got.last_of_run = res.last_of_run;
        if (expected_q.size() == 0)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t: unexpected result row %0d col %0d code %02h last %0b",
                         $realtime, got.row, got.col, got.code, got.last_of_run);
        end
        else
        begin
            want = expected_q.pop_front();
            if (got !== want)
            begin
                fail_total++;
                if (fail_total <= 10)
                    $display({"%0t: result mismatch: expected row %0d col %0d code %02h ",
                              "last %0b, got row %0d col %0d code %02h last %0b"},
                             $realtime, want.row, want.col, want.code, want.last_of_run,
                             got.row, got.col, got.code, got.last_of_run);
            end
        end
    endtask

    // sample every port at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    nbhd[i][j] = '0;
            next_row      = 0;
            next_col      = 0;
            width_reg     = CFG_W'(RESET_WIDTH);
            height_reg    = CFG_W'(RESET_HEIGHT);
            fail_total    = 0;
            expected_q.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            // a register write restarts the frame
            if (wr_en)
            begin
                case (cfg_reg_t'(wr_index))
                    CFG_IMAGE_WIDTH:  width_reg  = wr_data;
                    CFG_IMAGE_HEIGHT: height_reg = wr_data;
                    default: ;
                endcase
                next_row = 0;
                next_col = 0;
            end
            if (pix.valid && pix.ready)
                predict_pixel(pix.pixel);
            if (res.valid && res.ready)
                check_result();
            error_count   <= fail_total;
            pending_count <= expected_q.size();
        end
    end

endmodule

@@ verif/lbp_3x3_code_stream_tb.sv @@
// lbp_3x3_code_stream_tb: top of the lbp code stream test; makes pixel
// frames and register writes, stalls the result side, gives the verdict
// depends on lbp_pkg, lbp_if, lbp_3x3_code_stream and lbp_code_checker
`timescale 1ns / 1ps

module lbp_3x3_code_stream_tb;
    import lbp_pkg::*;

    localparam int RANDOM_PIXELS = 340;
    localparam int WIDE_EXTRA    = 40;

    typedef enum int {
        FILL_UNIFORM,
        FILL_NEAR,
        FILL_EXTREME
    } fill_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;
    logic                 calm = 1'b0;
    logic [CFG_W-1:0]     width_now;
    logic [CFG_W-1:0]     height_now;
    int unsigned          error_count;
    int unsigned          pending_count;

    lbp_pixel_if  pix_ch ();
    lbp_result_if res_ch ();

    lbp_3x3_code_stream u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pix      (pix_ch),
        .res      (res_ch)
    );

    lbp_code_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .pix           (pix_ch),
        .res           (res_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop if the stream hangs
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall bursts until the calm tail
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // one pixel transfer, sometimes after a short gap
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and let every expected result drain out
    task automatic finish_phase();
        pix_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (6) @(posedge clk);
    endtask

    // size writes, back to back when both are written
    task automatic set_frame(input logic do_w, input logic [CFG_W-1:0] w,
                             input logic do_h, input logic [CFG_W-1:0] h);
        if (do_w)
        begin
            wr_en     <= 1'b1;
            wr_index  <= CFG_IMAGE_WIDTH;
            wr_data   <= w;
            width_now  = w;
            @(posedge clk);
        end
        if (do_h)
        begin
            wr_en      <= 1'b1;
            wr_index   <= CFG_IMAGE_HEIGHT;
            wr_data    <= h;
            height_now  = h;
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input fill_t fill,
                                                    input logic [PIX_W-1:0] base);
        case (fill)
            FILL_NEAR:    return base + PIX_W'($urandom_range(0, 3));
            FILL_EXTREME:
                case ($urandom_range(0, 2))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return 8'h80;
                endcase
            default:      return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly 3..10, sometimes zero or below three
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(1, 2));
            default: return CFG_W'($urandom_range(3, 10));
        endcase
    endfunction

    initial
    begin
        logic [PIX_W-1:0] corner_set [6];
        logic [PIX_W-1:0] window_set [9];
        int unsigned      sent;
        int unsigned      fw;
        int unsigned      fh;
        int unsigned      count;
        logic             do_w;
        logic             do_h;
        fill_t            fill;
        logic [PIX_W-1:0] base;

        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= CFG_IMAGE_WIDTH;
        wr_data      <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        width_now     = CFG_W'(RESET_WIDTH);
        height_now    = CFG_W'(RESET_HEIGHT);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size, first row only: all pass through, then cut short by a write
        corner_set = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        foreach (corner_set[i])
            send_pixel(corner_set[i]);
        finish_phase();

        // 3x3 frame: equal, larger and smaller neighbours, two results on the last pixel
        set_frame(1'b1, 11'd3, 1'b1, 11'd3);
        window_set = '{8'd200, 8'd128, 8'd10, 8'd128, 8'd128, 8'd127,
                       8'd129, 8'd0, 8'd255};
        foreach (window_set[i])
            send_pixel(window_set[i]);
        finish_phase();

        // height zero acts as one row
        set_frame(1'b0, '0, 1'b1, '0);
        repeat (4) send_pixel(PIX_W'($urandom_range(0, 255)));
        finish_phase();

        // width zero too: single pixel frames
        set_frame(1'b1, '0, 1'b0, '0);
        repeat (2) send_pixel(PIX_W'($urandom_range(0, 255)));
        finish_phase();

        // oversize width clamps to the maximum, height at the maximum
        set_frame(1'b1, 11'h7FF, 1'b1, 11'd1024);
        repeat (DEF_MAX_WIDTH + WIDE_EXTRA)
            send_pixel(PIX_W'($urandom_range(0, 255)));
        finish_phase();

        // random small frames, mostly whole, some cut short by the next write
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 3))
                0:       {do_w, do_h} = 2'b10;
                1:       {do_w, do_h} = 2'b01;
                default: {do_w, do_h} = 2'b11;
            endcase
            if (sent == 0)
                {do_w, do_h} = 2'b11;
            set_frame(do_w, pick_dim(), do_h, pick_dim());
            fw = (width_now == 0) ? 1 : 32'(width_now);
            fh = (height_now == 0) ? 1 : 32'(height_now);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, fw * fh);
            else
                count = fw * fh * $urandom_range(1, 2);
            fill = fill_t'($urandom_range(0, 2));
            base = PIX_W'($urandom_range(0, 255));
            repeat (count)
            begin
                send_pixel(make_pixel(fill, base));
                sent++;
                if (sent == RANDOM_PIXELS * 4 / 5)
                    calm <= 1'b1;
            end
            finish_phase();
        end

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
